FILE: rtl/dihedral_angle_top_defines.svh
// Assertion macros shared by the dihedral angle block.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef DIHEDRAL_ANGLE_TOP_DEFINES_SVH
`define DIHEDRAL_ANGLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DIHANG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DIHANG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DIHANG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define DIHANG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/dihang_pkg.sv
`default_nettype none

package dihang_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int TORSION_WIDTH   = ANGLE_FRAC_BITS + 9;

  // Vectors are scaled so that every component magnitude is at most 2^30.
  localparam int RED_BITS = 30;
  localparam int BW       = COORD_WIDTH + 1;   // bond vector components
  localparam int RW       = RED_BITS + 1;      // reduced components, signed
  localparam int NW       = 2 * RW;            // products and cross products
  localparam int DOTW     = 2 * RW + 1;        // three-term dot products
  localparam int SQW      = 2 * RW;            // sum of squares, unsigned
  localparam int ROOTW    = RW;                // square root

  localparam int ACC_FRAC     = 32;
  localparam int RAD_FRAC     = 56;
  localparam int PRE_SHIFT    = 24;
  localparam int CORDIC_STEPS = 36;
  localparam int XW           = RW + PRE_SHIFT + 3;
  localparam int ZW           = ACC_FRAC + 10;
  localparam int HALF_TURN    = 180;
  localparam int QUARTER_TURN = 90;

  typedef struct packed {
    logic                 deg;
    logic                 neg;
    logic signed [RW-1:0] c;
  } sqrt_aux_t;

  typedef struct packed {
    logic deg;
    logic neg;
    logic zero;
  } rot_aux_t;

  function automatic logic signed [NW-1:0] smul(input logic signed [RW-1:0] a,
                                                input logic signed [RW-1:0] b);
    return NW'(a) * NW'(b);
  endfunction

  // Right shift that brings a magnitude word below 2^RED_BITS.
  function automatic logic [5:0] red_shift(input logic [63:0] orw);
    logic [5:0] k;
    k = '0;
    for (int i = RED_BITS; i < 64; i++) begin
      if (orw[i]) k = 6'(i - RED_BITS + 1);
    end
    return k;
  endfunction

  // Elaboration-time helpers for the arctangent table.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_series(input logic [63:0] p0, input logic [63:0] d);
    logic [63:0] p, sum, n, term;
    logic        sub, done;
    p    = p0;
    sum  = '0;
    n    = 64'd1;
    sub  = 1'b0;
    done = 1'b0;
    for (int t = 0; t < 64; t++) begin
      if (!done && p != '0) begin
        term = udiv(p, n);
        sum  = sub ? sum - term : sum + term;
        sub  = !sub;
        n    = n + 64'd2;
        if (d == '0) done = 1'b1;
        else p = udiv(p, d);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] to_deg(input logic [63:0] a, input logic [63:0] qp);
    logic [63:0] num, q, r;
    num = a * 64'd45;
    q   = udiv(num, qp);
    r   = num - q * qp;
    for (int i = 0; i < ACC_FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= qp) begin
        r    = r - qp;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees with ACC_FRAC fraction bits, truncated.
  function automatic logic [63:0] atan_deg(input int i);
    logic [63:0] one, qp, d;
    one = 64'd1 << RAD_FRAC;
    qp  = 64'd4 * atan_series(udiv(one, 64'd5), 64'd25)
        - atan_series(udiv(one, 64'd239), 64'd57121);
    d   = (2 * i < RAD_FRAC) ? (64'd1 << (2 * i)) : 64'd0;
    if (i == 0) return to_deg(qp, qp);
    return to_deg(atan_series(one >> i, d), qp);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dihang_isqrt.sv
`default_nettype none

module dihang_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic [dihang_pkg::SQW-1:0]   rad,
  input  dihang_pkg::sqrt_aux_t        aux_in,
  output logic                         vld_out,
  output logic [dihang_pkg::ROOTW-1:0] root_out,
  output dihang_pkg::sqrt_aux_t        aux_out
);
  import dihang_pkg::*;

  // One result bit per stage, restoring digit-by-digit square root.
  logic [SQW-1:0]     rd   [ROOTW+1];
  logic [ROOTW+1:0]   rem  [ROOTW+1];
  logic [ROOTW-1:0]   root [ROOTW+1];
  sqrt_aux_t          aux  [ROOTW+1];
  logic               vld  [ROOTW+1];

  assign rd[0]   = rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign aux[0]  = aux_in;
  assign vld[0]  = vld_in;

  for (genvar k = 0; k < ROOTW; k++) begin : g_step
    logic [ROOTW+1:0] cur, trial;
    assign cur   = {rem[k][ROOTW-1:0], rd[k][SQW-1 -: 2]};
    assign trial = {root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rd[k+1]  <= rd[k] << 2;
        aux[k+1] <= aux[k];
        if (cur >= trial) begin
          rem[k+1]  <= cur - trial;
          root[k+1] <= {root[k][ROOTW-2:0], 1'b1};
        end else begin
          rem[k+1]  <= cur;
          root[k+1] <= {root[k][ROOTW-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_out  = vld[ROOTW];
  assign root_out = root[ROOTW];
  assign aux_out  = aux[ROOTW];

endmodule

`default_nettype wire

FILE: rtl/dihang_cordic.sv
`default_nettype none

module dihang_cordic (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             vld_in,
  input  logic signed [dihang_pkg::XW-1:0] x_in,
  input  logic signed [dihang_pkg::XW-1:0] y_in,
  input  logic signed [dihang_pkg::ZW-1:0] z_in,
  input  dihang_pkg::rot_aux_t             aux_in,
  output logic                             vld_out,
  output logic signed [dihang_pkg::ZW-1:0] z_out,
  output dihang_pkg::rot_aux_t             aux_out
);
  import dihang_pkg::*;

  // Vectoring mode: one micro-rotation per stage drives y toward zero.
  logic signed [XW-1:0] x   [CORDIC_STEPS+1];
  logic signed [XW-1:0] y   [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z   [CORDIC_STEPS+1];
  rot_aux_t             aux [CORDIC_STEPS+1];
  logic                 vld [CORDIC_STEPS+1];

  assign x[0]   = x_in;
  assign y[0]   = y_in;
  assign z[0]   = z_in;
  assign aux[0] = aux_in;
  assign vld[0] = vld_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_deg(i));
    logic signed [XW-1:0] dx, dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        aux[i+1] <= aux[i];
        if (!y[i][XW-1]) begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + ANG;
        end else begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - ANG;
        end
      end
    end
  end

  assign vld_out = vld[CORDIC_STEPS];
  assign z_out   = z[CORDIC_STEPS];
  assign aux_out = aux[CORDIC_STEPS];

endmodule

`default_nettype wire

FILE: rtl/dihedral_angle_top.sv
`default_nettype none
// Torsion angle of four 3-D points, one quadruple per transaction.
// The input channel (item_valid / item_stall) carries the twelve signed
// coordinates p1_x .. p4_z. The result channel (result_valid / result_stall)
// carries torsion_deg, signed degrees with ANGLE_FRAC_BITS fraction bits in
// [-180, +180], and degenerate, which is set when one of the plane normals
// is zero; the angle is then 0.
// The datapath is a fixed pipeline of 81 register stages: 12 stages of bond
// vectors, cross products and scaling, 31 stages of square root (one root
// bit each), one pre-rotation stage, 36 CORDIC vectoring stages and the
// output register. One transaction is taken in every cycle unless the
// pipeline is frozen by result_stall, so the throughput is one quadruple
// per clock while the result channel is not stalled.
// Reset (synchronous, active high) clears every stage's valid bit and
// result_valid; the data registers, torsion_deg and degenerate are not reset.
// While result_valid is high and the receiver holds result_stall, the whole
// pipeline freezes and item_stall is raised, so no transaction is lost or
// repeated; the pipeline resumes on the first cycle the stall drops.
`include "dihedral_angle_top_defines.svh"

module dihedral_angle_top (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          item_valid,
  output logic                                          item_stall,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p1_x,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p1_y,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p1_z,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p2_x,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p2_y,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p2_z,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p3_x,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p3_y,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p3_z,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p4_x,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p4_y,
  input  logic signed [dihang_pkg::COORD_WIDTH-1:0]     p4_z,
  output logic                                          result_valid,
  input  logic                                          result_stall,
  output logic signed [dihang_pkg::TORSION_WIDTH-1:0]   torsion_deg,
  output logic                                          degenerate
);
  import dihang_pkg::*;

  localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] Z_MAX = ZW'(HALF_TURN) <<< ACC_FRAC;
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(QUARTER_TURN) <<< ACC_FRAC;
  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1) <<< (SH - 1);
  localparam logic signed [ZW-1:0] R_MAX = ZW'(HALF_TURN) <<< ANGLE_FRAC_BITS;
  localparam logic signed [TORSION_WIDTH-1:0] T_MAX =
    TORSION_WIDTH'(HALF_TURN) <<< ANGLE_FRAC_BITS;

  // The whole pipeline advances together unless a finished result is held.
  logic en;
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  logic [12:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[11:1], item_valid};
    end
  end

  logic signed [COORD_WIDTH-1:0] pt [4][3];
  assign pt[0][0] = p1_x;
  assign pt[0][1] = p1_y;
  assign pt[0][2] = p1_z;
  assign pt[1][0] = p2_x;
  assign pt[1][1] = p2_y;
  assign pt[1][2] = p2_z;
  assign pt[2][0] = p3_x;
  assign pt[2][1] = p3_y;
  assign pt[2][2] = p3_z;
  assign pt[3][0] = p4_x;
  assign pt[3][1] = p4_y;
  assign pt[3][2] = p4_z;

  // Stage 1: bond vectors b1, b2, b3.
  logic signed [BW-1:0] s1_b [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          s1_b[j][i] <= BW'(pt[j+1][i]) - BW'(pt[j][i]);
        end
      end
    end
  end

  // Stage 2: scale each bond vector so its components fit in RW bits.
  logic signed [RW-1:0] red_b [3][3];
  logic signed [RW-1:0] s2_b  [3][3];

  always_comb begin
    logic [BW-1:0] m;
    logic [63:0]   orw;
    logic [5:0]    k;
    for (int j = 0; j < 3; j++) begin
      orw = '0;
      for (int i = 0; i < 3; i++) begin
        m   = s1_b[j][i][BW-1] ? BW'(-s1_b[j][i]) : BW'(s1_b[j][i]);
        orw = orw | 64'(m);
      end
      k = red_shift(orw);
      for (int i = 0; i < 3; i++) begin
        red_b[j][i] = RW'(s1_b[j][i] >>> k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_b <= red_b;
    end
  end

  // Stage 3: partial products of n1 = b1 x b2 and n2 = b2 x b3.
  logic signed [NW-1:0] s3_pr [2][6];
  logic signed [RW-1:0] s3_b2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        s3_pr[c][0] <= smul(s2_b[c][1], s2_b[c+1][2]);
        s3_pr[c][1] <= smul(s2_b[c][2], s2_b[c+1][1]);
        s3_pr[c][2] <= smul(s2_b[c][2], s2_b[c+1][0]);
        s3_pr[c][3] <= smul(s2_b[c][0], s2_b[c+1][2]);
        s3_pr[c][4] <= smul(s2_b[c][0], s2_b[c+1][1]);
        s3_pr[c][5] <= smul(s2_b[c][1], s2_b[c+1][0]);
      end
      s3_b2 <= s2_b[1];
    end
  end

  // Stage 4: the normals.
  logic signed [NW-1:0] s4_n  [2][3];
  logic signed [RW-1:0] s4_b2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        s4_n[c][0] <= s3_pr[c][0] - s3_pr[c][1];
        s4_n[c][1] <= s3_pr[c][2] - s3_pr[c][3];
        s4_n[c][2] <= s3_pr[c][4] - s3_pr[c][5];
      end
      s4_b2 <= s3_b2;
    end
  end

  // Stage 5: magnitude words of the normals and the zero-normal check.
  logic [NW-1:0]        n_or [2];
  logic                 n_zero [2];
  logic signed [NW-1:0] s5_n  [2][3];
  logic [NW-1:0]        s5_or [2];
  logic                 s5_deg;
  logic signed [RW-1:0] s5_b2 [3];

  always_comb begin
    logic [NW-1:0] m;
    for (int c = 0; c < 2; c++) begin
      n_or[c]   = '0;
      n_zero[c] = 1'b1;
      for (int i = 0; i < 3; i++) begin
        m         = s4_n[c][i][NW-1] ? NW'(-s4_n[c][i]) : NW'(s4_n[c][i]);
        n_or[c]   = n_or[c] | m;
        n_zero[c] = n_zero[c] && (s4_n[c][i] == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_n   <= s4_n;
      s5_or  <= n_or;
      s5_deg <= n_zero[0] || n_zero[1];
      s5_b2  <= s4_b2;
    end
  end

  // Stage 6: scale each normal.
  logic signed [RW-1:0] s6_n  [2][3];
  logic                 s6_deg;
  logic signed [RW-1:0] s6_b2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < 3; i++) begin
          s6_n[c][i] <= RW'(s5_n[c][i] >>> red_shift(64'(s5_or[c])));
        end
      end
      s6_deg <= s5_deg;
      s6_b2  <= s5_b2;
    end
  end

  // Stage 7: partial products of w = n1 x n2 and of n1 . n2.
  logic signed [NW-1:0] s7_pr [9];
  logic                 s7_deg;
  logic signed [RW-1:0] s7_b2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s7_pr[0] <= smul(s6_n[0][1], s6_n[1][2]);
      s7_pr[1] <= smul(s6_n[0][2], s6_n[1][1]);
      s7_pr[2] <= smul(s6_n[0][2], s6_n[1][0]);
      s7_pr[3] <= smul(s6_n[0][0], s6_n[1][2]);
      s7_pr[4] <= smul(s6_n[0][0], s6_n[1][1]);
      s7_pr[5] <= smul(s6_n[0][1], s6_n[1][0]);
      s7_pr[6] <= smul(s6_n[0][0], s6_n[1][0]);
      s7_pr[7] <= smul(s6_n[0][1], s6_n[1][1]);
      s7_pr[8] <= smul(s6_n[0][2], s6_n[1][2]);
      s7_deg   <= s6_deg;
      s7_b2    <= s6_b2;
    end
  end

  // Stage 8: the sine vector w and the cosine term.
  logic signed [DOTW-1:0] s8_w [4];
  logic                   s8_deg;
  logic signed [RW-1:0]   s8_b2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s8_w[0] <= DOTW'(s7_pr[0] - s7_pr[1]);
      s8_w[1] <= DOTW'(s7_pr[2] - s7_pr[3]);
      s8_w[2] <= DOTW'(s7_pr[4] - s7_pr[5]);
      s8_w[3] <= DOTW'(s7_pr[6]) + DOTW'(s7_pr[7]) + DOTW'(s7_pr[8]);
      s8_deg  <= s7_deg;
      s8_b2   <= s7_b2;
    end
  end

  // Stage 9: one magnitude word over all four values.
  logic [DOTW-1:0]        w_or;
  logic signed [DOTW-1:0] s9_w [4];
  logic [DOTW-1:0]        s9_or;
  logic                   s9_deg;
  logic signed [RW-1:0]   s9_b2 [3];

  always_comb begin
    logic [DOTW-1:0] m;
    w_or = '0;
    for (int i = 0; i < 4; i++) begin
      m    = s8_w[i][DOTW-1] ? DOTW'(-s8_w[i]) : DOTW'(s8_w[i]);
      w_or = w_or | m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_w   <= s8_w;
      s9_or  <= w_or;
      s9_deg <= s8_deg;
      s9_b2  <= s8_b2;
    end
  end

  // Stage 10: scale the four values together.
  logic signed [RW-1:0] s10_w [4];
  logic                 s10_deg;
  logic signed [RW-1:0] s10_b2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s10_w[i] <= RW'(s9_w[i] >>> red_shift(64'(s9_or)));
      end
      s10_deg <= s9_deg;
      s10_b2  <= s9_b2;
    end
  end

  // Stage 11: squares of w and the triple product terms b2 . w.
  logic signed [NW-1:0] s11_sq [3];
  logic signed [NW-1:0] s11_tp [3];
  logic signed [RW-1:0] s11_c;
  logic                 s11_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s11_sq[i] <= smul(s10_w[i], s10_w[i]);
        s11_tp[i] <= smul(s10_b2[i], s10_w[i]);
      end
      s11_c   <= s10_w[3];
      s11_deg <= s10_deg;
    end
  end

  // Stage 12: sum of squares and the sign of the triple product.
  logic [SQW-1:0]         s12_ss;
  sqrt_aux_t              s12_aux;
  logic signed [DOTW-1:0] tp_sum;

  assign tp_sum = DOTW'(s11_tp[0]) + DOTW'(s11_tp[1]) + DOTW'(s11_tp[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s12_ss      <= SQW'(s11_sq[0]) + SQW'(s11_sq[1]) + SQW'(s11_sq[2]);
      s12_aux.deg <= s11_deg;
      s12_aux.neg <= tp_sum[DOTW-1];
      s12_aux.c   <= s11_c;
    end
  end

  // Square root of the sum of squares gives the sine term S.
  logic             sq_vld;
  logic [ROOTW-1:0] sq_root;
  sqrt_aux_t        sq_aux;

  dihang_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (vld[12]),
    .rad      (s12_ss),
    .aux_in   (s12_aux),
    .vld_out  (sq_vld),
    .root_out (sq_root),
    .aux_out  (sq_aux)
  );

  // Pre-rotation: a negative cosine is turned by 90 degrees into the
  // right half plane, then both coordinates are scaled up for the CORDIC.
  logic signed [XW-1:0] pre_x, pre_y;
  logic                 pre_vld;
  logic signed [XW-1:0] s13_x, s13_y;
  logic signed [ZW-1:0] s13_z;
  rot_aux_t             s13_aux;

  always_comb begin
    if (!sq_aux.c[RW-1]) begin
      pre_x = XW'(sq_aux.c);
      pre_y = XW'(sq_root);
    end else begin
      pre_x = XW'(sq_root);
      pre_y = -XW'(sq_aux.c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= 1'b0;
    end else if (en) begin
      pre_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s13_x        <= pre_x <<< PRE_SHIFT;
      s13_y        <= pre_y <<< PRE_SHIFT;
      s13_z        <= sq_aux.c[RW-1] ? Z_QUARTER : '0;
      s13_aux.deg  <= sq_aux.deg;
      s13_aux.neg  <= sq_aux.neg;
      s13_aux.zero <= (pre_x == '0) && (pre_y == '0);
    end
  end

  logic                 cor_vld;
  logic signed [ZW-1:0] cor_z;
  rot_aux_t             cor_aux;

  dihang_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (pre_vld),
    .x_in    (s13_x),
    .y_in    (s13_y),
    .z_in    (s13_z),
    .aux_in  (s13_aux),
    .vld_out (cor_vld),
    .z_out   (cor_z),
    .aux_out (cor_aux)
  );

  // Output: clamp to [0, 180], round half up, cap, apply the sign, and force 0 when degenerate.
  logic signed [ZW-1:0]            zc, rs;
  logic signed [TORSION_WIDTH-1:0] tv;

  always_comb begin
    if (cor_z[ZW-1]) begin
      zc = '0;
    end else if (cor_z > Z_MAX) begin
      zc = Z_MAX;
    end else begin
      zc = cor_z;
    end
    rs = (zc + ROUND_HALF) >>> SH;
    if (rs > R_MAX) begin
      rs = R_MAX;
    end
    tv = TORSION_WIDTH'(rs);
    if (cor_aux.neg) begin
      tv = -tv;
    end
    if (cor_aux.zero || cor_aux.deg) begin
      tv = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= cor_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      torsion_deg <= tv;
      degenerate  <= cor_aux.deg;
    end
  end

  `DIHANG_ASSERT_IMP(a_deg_zero, clk, rst, result_valid && degenerate, torsion_deg == '0, "degenerate result with a nonzero angle")
  `DIHANG_ASSERT_IMP(a_range, clk, rst, result_valid, (torsion_deg <= T_MAX) && (torsion_deg >= -T_MAX), "angle outside half turn")
  `DIHANG_ASSERT_NXT(a_freeze, clk, rst, !en, $stable(vld) && $stable(pre_vld), "pipeline moved while the result was held")

endmodule

`default_nettype wire
